// ===== rtl/websocket_frame_deframer_assert.svh =====
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Checked every clock, masked while reset is asserted.
`define WSFD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked every clock, including during reset.
`define WSFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wsfd_pkg.sv =====
package wsfd_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_B0,
    PH_B1,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_t;

  localparam logic KIND_HDR  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_BYTES = 3'd0;  // counts down through 7 to 0: eight bytes
  localparam logic [2:0] KEY_LAST    = 3'd3;

  // Queue between parser and output stage; depth must be a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified result on its way to the output stage
  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  op;
    logic        mask;
    logic [63:0] len;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        last;
  } qent_t;

endpackage

// ===== rtl/wsfd_front.sv =====
module wsfd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    rx_byte,
  output logic          push,
  output wsfd_pkg::qent_t push_ent
);
  import wsfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [2:0]  rsv_r, rsv_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] len_r, len_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic [1:0]  koff_r, koff_nxt;

  logic [6:0]  len7;
  logic [2:0]  cnt_dec;
  logic [63:0] ext_len;
  logic [7:0]  key_byte;

  assign len7    = rx_byte[6:0];
  assign cnt_dec = cnt_r - 3'd1;
  assign ext_len = {len_r[55:0], rx_byte};

  always_comb begin
    unique case (koff_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (phase_r)
        PH_B1: begin
          if (len7 == LEN_EXT16 || len7 == LEN_EXT64) phase_nxt = PH_EXT;
          else if (rx_byte[7])                        phase_nxt = PH_KEY;
          else if (len7 == 7'd0)                      phase_nxt = PH_B0;
          else                                        phase_nxt = PH_DATA;
        end
        PH_EXT: begin
          if (cnt_dec == 3'd0) begin
            if (mask_r)                phase_nxt = PH_KEY;
            else if (ext_len == 64'd0) phase_nxt = PH_B0;
            else                       phase_nxt = PH_DATA;
          end
        end
        PH_KEY: begin
          if (cnt_r == KEY_LAST) phase_nxt = (len_r == 64'd0) ? PH_B0 : PH_DATA;
        end
        PH_DATA: begin
          if (remain_r == 64'd1) phase_nxt = PH_B0;
        end
        default: phase_nxt = PH_B1;
      endcase
    end
  end

  // Header fields, counters and queue entry
  always_comb begin
    fin_nxt    = fin_r;
    rsv_nxt    = rsv_r;
    op_nxt     = op_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    remain_nxt = remain_r;
    koff_nxt   = koff_r;
    push       = 1'b0;

    push_ent.kind = KIND_HDR;
    push_ent.fin  = fin_r;
    push_ent.rsv  = rsv_r;
    push_ent.op   = op_r;
    push_ent.mask = mask_r;
    push_ent.len  = len_r;
    push_ent.data = 8'd0;
    push_ent.key  = 8'd0;
    push_ent.last = (len_r == 64'd0);

    if (acc) begin
      unique case (phase_r)
        PH_B1: begin
          mask_nxt = rx_byte[7];
          koff_nxt = 2'd0;
          if (len7 == LEN_EXT16) begin
            len_nxt = 64'd0;
            cnt_nxt = EXT16_BYTES;
          end else if (len7 == LEN_EXT64) begin
            len_nxt = 64'd0;
            cnt_nxt = EXT64_BYTES;
          end else begin
            len_nxt    = {57'd0, len7};
            cnt_nxt    = 3'd0;
            remain_nxt = {57'd0, len7};
            push          = !rx_byte[7];
            push_ent.mask = 1'b0;
            push_ent.len  = {57'd0, len7};
            push_ent.last = (len7 == 7'd0);
          end
        end
        PH_EXT: begin
          len_nxt = ext_len;
          cnt_nxt = cnt_dec;
          if (cnt_dec == 3'd0) begin
            remain_nxt    = ext_len;
            push          = !mask_r;
            push_ent.len  = ext_len;
            push_ent.last = (ext_len == 64'd0);
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], rx_byte};
          if (cnt_r == KEY_LAST) begin
            cnt_nxt    = 3'd0;
            remain_nxt = len_r;
            push       = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_DATA: begin
          remain_nxt    = remain_r - 64'd1;
          koff_nxt      = koff_r + 2'd1;
          push          = 1'b1;
          push_ent.kind = KIND_DATA;
          push_ent.data = rx_byte;
          push_ent.key  = mask_r ? key_byte : 8'd0;
          push_ent.last = (remain_r == 64'd1);
        end
        default: begin
          fin_nxt  = rx_byte[7];
          rsv_nxt  = rx_byte[6:4];
          op_nxt   = rx_byte[3:0];
          mask_nxt = 1'b0;
          len_nxt  = 64'd0;
          cnt_nxt  = 3'd0;
          key_nxt  = 32'd0;
          koff_nxt = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_B0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r    <= fin_nxt;
    rsv_r    <= rsv_nxt;
    op_r     <= op_nxt;
    mask_r   <= mask_nxt;
    len_r    <= len_nxt;
    cnt_r    <= cnt_nxt;
    key_r    <= key_nxt;
    remain_r <= remain_nxt;
    koff_r   <= koff_nxt;
  end

endmodule

// ===== rtl/wsfd_fifo.sv =====
`include "websocket_frame_deframer_assert.svh"

module wsfd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wsfd_pkg::qent_t push_ent,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output wsfd_pkg::qent_t head_ent
);
  import wsfd_pkg::*;

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign head_ent = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
  assign count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `WSFD_ASSERT_RST(a_no_overflow, !(push && full), "queue written while full")
  `WSFD_ASSERT_RST(a_no_underflow, !(pop && empty), "queue read while empty")
  `WSFD_ASSERT(a_count_range, !rst_n || (count_r <= QCNT_W'(QDEPTH)), "queue count out of range")
  `WSFD_ASSERT_RST(a_ptr_match, (count_r == '0) |-> (wr_ptr_r == rd_ptr_r), "pointers differ on empty queue")

endmodule

// ===== rtl/wsfd_back.sv =====
module wsfd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            empty,
  input  wsfd_pkg::qent_t head_ent,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_item_kind,
  output logic            out_fin_flag,
  output logic [2:0]      out_rsv_bits,
  output logic [3:0]      out_frame_opcode,
  output logic            out_masked_flag,
  output logic [63:0]     out_frame_length,
  output logic [7:0]      out_data_byte,
  output logic            out_last_of_frame
);
  import wsfd_pkg::*;

  logic  vld_r, vld_nxt;
  qent_t res_r, res_nxt;
  logic  load;

  // Output register refills whenever it is empty or its transfer completes
  assign load    = !vld_r || out_ready;
  assign pop     = load && !empty;
  assign vld_nxt = load ? !empty : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Unmask on the way into the register; key byte is zero when unmasked
  always_comb begin
    res_nxt      = head_ent;
    res_nxt.data = head_ent.data ^ head_ent.key;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = vld_r;
  assign out_item_kind     = res_r.kind;
  assign out_fin_flag      = res_r.fin;
  assign out_rsv_bits      = res_r.rsv;
  assign out_frame_opcode  = res_r.op;
  assign out_masked_flag   = res_r.mask;
  assign out_frame_length  = res_r.len;
  assign out_data_byte     = res_r.data;
  assign out_last_of_frame = res_r.last;

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// Path: a byte that completes a header, or a payload byte, is written into the queue by the
//   parser, then registered and unmasked by the output stage before it shows on out_*.
// Throughput: one byte per clock, sustained, as long as out_ready stays high; the two-entry
//   queue plus output register absorb output stalls.
// Reset (rst_n low, synchronous): parser expects the first header byte, queue and output empty.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // received byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // parsed results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_item_kind,
  output logic        out_fin_flag,
  output logic [2:0]  out_rsv_bits,
  output logic [3:0]  out_frame_opcode,
  output logic        out_masked_flag,
  output logic [63:0] out_frame_length,
  output logic [7:0]  out_data_byte,
  output logic        out_last_of_frame
);
  import wsfd_pkg::*;

  logic  acc;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  qent_t push_ent;
  qent_t head_ent;

  // Input side stalls only when the queue is full; header bytes that
  // produce no result still need a free slot, which keeps the check simple.
  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  // Front: header parser and payload classifier. Tracks the phase,
  // builds the extended length big-endian, collects the masking key and
  // picks the key byte by payload offset mod 4.
  wsfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .rx_byte  (in_rx_byte),
    .push     (push),
    .push_ent (push_ent)
  );

  // Short queue decoupling the parser from the output handshake
  wsfd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head_ent (head_ent)
  );

  // Back: XOR unmask into the output register, drives the result transfer
  wsfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty             (empty),
    .head_ent          (head_ent),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item_kind     (out_item_kind),
    .out_fin_flag      (out_fin_flag),
    .out_rsv_bits      (out_rsv_bits),
    .out_frame_opcode  (out_frame_opcode),
    .out_masked_flag   (out_masked_flag),
    .out_frame_length  (out_frame_length),
    .out_data_byte     (out_data_byte),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

// ===== tb/ws_deframe_checker.sv =====
module ws_deframe_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_item_kind,
  input  logic        out_fin_flag,
  input  logic [2:0]  out_rsv_bits,
  input  logic [3:0]  out_frame_opcode,
  input  logic        out_masked_flag,
  input  logic [63:0] out_frame_length,
  input  logic [7:0]  out_data_byte,
  input  logic        out_last_of_frame,
  output int          mismatch_count,
  output int          items_due,
  output int          headers_seen,
  output int          payload_seen
);
  import wsfd_pkg::*;

  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  op;
    logic        mask;
    logic [63:0] len;
    logic [7:0]  data;
    logic        last;
  } frame_item_t;

  localparam int MAX_REPORTS = 50;

  string field_name [8] = '{"item_kind", "fin_flag", "rsv_bits", "frame_opcode",
                            "masked_flag", "frame_length", "data_byte", "last_of_frame"};

  frame_item_t frame_items_due [$];

  // parser state as seen from the byte stream
  phase_t      ps      = PH_B0;
  logic        fin_r   = 1'b0;
  logic [2:0]  rsv_r   = '0;
  logic [3:0]  op_r    = '0;
  logic        mask_r  = 1'b0;
  logic [63:0] len_r   = '0;
  logic [31:0] key_r   = '0;
  logic [63:0] offs_r  = '0;
  int          ext_left = 0;
  int          key_idx  = 0;

  int errors = 0;
  int hdrs   = 0;
  int bytes  = 0;

  function automatic frame_item_t item_of(logic kind, logic [7:0] data, logic last);
    return {kind, fin_r, rsv_r, op_r, mask_r, len_r, data, last};
  endfunction

  function automatic void split_fields(input frame_item_t r, output logic [63:0] f [8]);
    f[0] = 64'(r.kind);
    f[1] = 64'(r.fin);
    f[2] = 64'(r.rsv);
    f[3] = 64'(r.op);
    f[4] = 64'(r.mask);
    f[5] = r.len;
    f[6] = 64'(r.data);
    f[7] = 64'(r.last);
  endfunction

  task automatic close_header(output bit emit, output frame_item_t r);
    logic zero_len;
    zero_len = (len_r == 64'd0);
    offs_r   = '0;
    ps       = zero_len ? PH_B0 : PH_DATA;
    r        = item_of(KIND_HDR, 8'h00, zero_len);
    emit     = 1'b1;
  endtask

  task automatic length_complete(output bit emit, output frame_item_t r);
    emit = 1'b0;
    r    = '0;
    if (mask_r) begin
      key_idx = 0;
      ps      = PH_KEY;
    end else begin
      close_header(emit, r);
    end
  endtask

  // one received byte through the frame parser
  task automatic deframe_byte(input logic [7:0] b, output bit emit, output frame_item_t r);
    logic [7:0] kb;
    emit = 1'b0;
    r    = '0;
    case (ps)
      PH_B1: begin
        mask_r = b[7];
        len_r  = {57'd0, b[6:0]};
        if (b[6:0] == LEN_EXT16) begin
          len_r    = '0;
          ext_left = 2;
          ps       = PH_EXT;
        end else if (b[6:0] == LEN_EXT64) begin
          len_r    = '0;
          ext_left = 8;
          ps       = PH_EXT;
        end else begin
          length_complete(emit, r);
        end
      end
      PH_EXT: begin
        len_r = {len_r[55:0], b};
        ext_left--;
        if (ext_left == 0) length_complete(emit, r);
      end
      PH_KEY: begin
        key_r = {key_r[23:0], b};
        key_idx++;
        if (key_idx == 4) begin
          key_idx = 0;
          close_header(emit, r);
        end
      end
      PH_DATA: begin
        kb     = mask_r ? key_r[31 - 8 * offs_r[1:0] -: 8] : 8'h00;
        offs_r = offs_r + 64'd1;
        r      = item_of(KIND_DATA, b ^ kb, offs_r >= len_r);
        if (offs_r >= len_r) ps = PH_B0;
        emit = 1'b1;
      end
      default: begin
        fin_r    = b[7];
        rsv_r    = b[6:4];
        op_r     = b[3:0];
        mask_r   = 1'b0;
        len_r    = '0;
        key_r    = '0;
        offs_r   = '0;
        ext_left = 0;
        key_idx  = 0;
        ps       = PH_B1;
      end
    endcase
  endtask

  always @(posedge clk) begin
    frame_item_t got;
    frame_item_t want;
    frame_item_t nxt;
    logic [63:0] got_f [8];
    logic [63:0] want_f [8];
    bit emit;
    if (!rst_n) begin
      ps       = PH_B0;
      fin_r    = 1'b0;
      rsv_r    = '0;
      op_r     = '0;
      mask_r   = 1'b0;
      len_r    = '0;
      key_r    = '0;
      offs_r   = '0;
      ext_left = 0;
      key_idx  = 0;
      frame_items_due.delete();
    end else begin
      // result side first, so a result can never match an item taken at this same edge
      if (out_valid && out_ready) begin
        got = {out_item_kind, out_fin_flag, out_rsv_bits, out_frame_opcode, out_masked_flag,
               out_frame_length, out_data_byte, out_last_of_frame};
        if (frame_items_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result: expected none, got kind=%0d len=%0h %s%02h %s%0d",
                     $time, got.kind, got.len, "data=", got.data, "last=", got.last);
        end else begin
          want = frame_items_due.pop_front();
          split_fields(want, want_f);
          split_fields(got, got_f);
          for (int i = 0; i < 8; i++) begin
            if (want_f[i] !== got_f[i]) begin
              errors++;
              if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h, got %0h",
                         $time, field_name[i], want_f[i], got_f[i]);
            end
          end
          if (want.kind == KIND_HDR) hdrs++;
          else bytes++;
        end
      end
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte, emit, nxt);
        if (emit) frame_items_due.push_back(nxt);
      end
    end
    mismatch_count <= errors;
    items_due      <= frame_items_due.size();
    headers_seen   <= hdrs;
    payload_seen   <= bytes;
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import wsfd_pkg::*;

  // Quiet cycles (no transfer on either channel) before the run is declared hung.
  // With 86% idling, a gap anywhere near the limit is practically impossible.
  localparam int STALL_LIMIT = 5000;
  // Random stream bytes per flow-control mode
  localparam int MODE_BYTES  = 280;
  // Cycles to linger after the last result
  localparam int TAIL_CYCLES = 10;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte  = 8'h00;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic        out_item_kind;
  logic        out_fin_flag;
  logic [2:0]  out_rsv_bits;
  logic [3:0]  out_frame_opcode;
  logic        out_masked_flag;
  logic [63:0] out_frame_length;
  logic [7:0]  out_data_byte;
  logic        out_last_of_frame;

  int mismatch_count;
  int items_due;
  int headers_seen;
  int payload_seen;

  // flow-control knobs, percent of cycles, then byte and quiet-cycle counters
  int snd_idle     = 0;
  int rcv_stall    = 0;
  int bytes_sent   = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  websocket_frame_deframer u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item_kind     (out_item_kind),
    .out_fin_flag      (out_fin_flag),
    .out_rsv_bits      (out_rsv_bits),
    .out_frame_opcode  (out_frame_opcode),
    .out_masked_flag   (out_masked_flag),
    .out_frame_length  (out_frame_length),
    .out_data_byte     (out_data_byte),
    .out_last_of_frame (out_last_of_frame)
  );

  // Watches both channels, predicts every result and compares it
  ws_deframe_checker u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item_kind     (out_item_kind),
    .out_fin_flag      (out_fin_flag),
    .out_rsv_bits      (out_rsv_bits),
    .out_frame_opcode  (out_frame_opcode),
    .out_masked_flag   (out_masked_flag),
    .out_frame_length  (out_frame_length),
    .out_data_byte     (out_data_byte),
    .out_last_of_frame (out_last_of_frame),
    .mismatch_count    (mismatch_count),
    .items_due         (items_due),
    .headers_seen      (headers_seen),
    .payload_seen      (payload_seen)
  );

  // Receiver: ready drawn fresh every cycle, held low through reset
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= rcv_stall);
  end

  // Watchdog: any transfer on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results still due",
               $time, STALL_LIMIT, items_due);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One byte transfer. Random idle cycles go in front; once valid rises it stays
  // up with the byte unchanged until the transfer happens.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // One well-formed frame with random header bits, mask, key and payload.
  // Lengths lean short; 16- and 64-bit length fields carry small values, so
  // non-minimal encodings show up. With top_bit_len the 64-bit length has its
  // top bit set: the frame never ends, so it only goes at the very end of the
  // stream, followed by a handful of payload bytes.
  task automatic send_frame(input bit top_bit_len);
    logic [7:0]  b0;
    logic [6:0]  code;
    logic [63:0] n;
    logic [31:0] key;
    bit          masked;
    int          ext_bytes;
    int          sel;
    int          body;
    b0        = 8'($urandom);
    masked    = 1'($urandom_range(1));
    key       = $urandom;
    sel       = int'($urandom_range(99));
    ext_bytes = 0;
    if (top_bit_len) begin
      n         = {$urandom, $urandom};
      n[63]     = 1'b1;
      ext_bytes = 8;
    end else if (sel < 10) begin
      n = 64'd0;
    end else if (sel < 65) begin
      n = 64'($urandom_range(20));
    end else if (sel < 85) begin
      n = 64'($urandom_range(125));
    end else if (sel < 93) begin
      n         = 64'($urandom_range(300));
      ext_bytes = 2;
    end else begin
      n         = 64'($urandom_range(150));
      ext_bytes = 8;
    end
    code = (ext_bytes == 2) ? LEN_EXT16 : (ext_bytes == 8) ? LEN_EXT64 : n[6:0];
    body = top_bit_len ? 12 : int'(n);
    send_byte(b0);
    send_byte({masked, code});
    // extended length goes big-endian
    for (int i = ext_bytes - 1; i >= 0; i--) send_byte(n[8*i +: 8]);
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
    repeat (body) send_byte(8'($urandom));
  endtask

  // Sender holds off until every predicted result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (items_due != 0) @(posedge clk);
  endtask

  initial begin
    // Directed opening:
    //  - all header bits set (FIN, RSV 7, reserved opcode 15), zero length, no mask
    //  - masked length 2, payload hits both extremes against the key
    //  - 16-bit length field holding 1 (non-minimal), unmasked byte passes through
    //  - FIN clear, 64-bit length field holding 1
    logic [7:0] opening [26] = '{
      8'hFF, 8'h00,
      8'h81, 8'h82, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h00,
      8'h02, 8'h7E, 8'h00, 8'h01, 8'h80,
      8'h70, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h55
    };
    // Flow-control modes: none, sender mostly idle, receiver mostly stalled, both
    int idle_pct  [4] = '{0, 86, 0, 29};
    int stall_pct [4] = '{0, 0, 86, 29};
    int mode_start;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int m = 0; m < 4; m++) begin
      snd_idle  = idle_pct[m];
      rcv_stall = stall_pct[m];
      if (m == 0) begin
        foreach (opening[i]) send_byte(opening[i]);
      end
      mode_start = bytes_sent;
      while (bytes_sent - mode_start < MODE_BYTES) send_frame(1'b0);
      // endless frame with a top-bit length closes out the stream
      if (m == 3) send_frame(1'b1);
      // pause between modes until the block has delivered everything
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes under four flow-control modes; checked %0d frame headers",
             bytes_sent, headers_seen);
    $display("and %0d unmasked payload bytes, %0d field mismatches", payload_seen,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wsfd_pkg.sv
rtl/wsfd_front.sv
rtl/wsfd_fifo.sv
rtl/wsfd_back.sv
rtl/websocket_frame_deframer.sv
tb/ws_deframe_checker.sv
tb/testbench.sv
